>>> hw/rtl/fp8_e4m3_arith_unit_defines.svh
// Assertion macros for the FP8 E4M3 arithmetic unit checker.
// Depends on nothing; included by the checker file.
`ifndef FP8_E4M3_ARITH_UNIT_DEFINES_SVH
`define FP8_E4M3_ARITH_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FP8EA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fp8ea checker: implication failed");

// condition that must hold on every clock edge outside reset
`define FP8EA_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("fp8ea checker: invariant failed");

`endif

>>> hw/rtl/fp8ea_pkg.sv
// Shared types, codes and helper functions of the FP8 E4M3 arithmetic unit.
// No dependencies.
package fp8ea_pkg;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_MUL = 3'd1;
   localparam logic [2:0] MODE_FMA = 3'd2;
   localparam logic [2:0] MODE_CMP = 3'd3;
   localparam logic [2:0] MODE_CLS = 3'd4;
   localparam logic [2:0] MODE_CVT = 3'd5;

   localparam logic [2:0] RM_RNE = 3'd0;
   localparam logic [2:0] RM_RNA = 3'd1;
   localparam logic [2:0] RM_RZ  = 3'd2;
   localparam logic [2:0] RM_RU  = 3'd3;
   localparam logic [2:0] RM_RD  = 3'd4;

   localparam logic [1:0] CMP_LT = 2'd0;
   localparam logic [1:0] CMP_EQ = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;
   localparam logic [1:0] CMP_UN = 2'd3;

   localparam logic [2:0] CLS_ZERO = 3'd0;
   localparam logic [2:0] CLS_SUB  = 3'd1;
   localparam logic [2:0] CLS_NORM = 3'd2;
   localparam logic [2:0] CLS_INF  = 3'd3;
   localparam logic [2:0] CLS_NAN  = 3'd4;

   localparam logic [7:0] FP8_QNAN = 8'h79;
   localparam int unsigned MagW = 34;  // fixed-point frame, LSB = 2^-18
   localparam int unsigned SumW = 35;

   typedef struct packed {
      logic       valid;
      logic       special;
      logic [7:0] spec_res;
      logic [1:0] cmp;
      logic [2:0] cls;
      logic [2:0] rm;
      logic       zsign;
   } fp8ea_ctl_type;

   typedef struct packed {
      logic [7:0]  pm;
      logic [4:0]  pshift;
      logic        psign;
      logic [3:0]  cm;
      logic [4:0]  cshift;
      logic        csign;
      logic        use64;
      logic        s64;
      logic [26:0] m64;
      logic        sticky;
   } fp8ea_dec_type;

   function automatic logic [7:0] overflow8(input logic s, input logic [2:0] rm);
      logic [7:0] r;
      case (rm)
         RM_RNE, RM_RNA: r = {s, 7'h78};
         RM_RU:          r = s ? {s, 7'h77} : {s, 7'h78};
         RM_RD:          r = s ? {s, 7'h78} : {s, 7'h77};
         default:        r = {s, 7'h77};
      endcase
      return r;
   endfunction

   function automatic logic [2:0] classify8(input logic [7:0] v);
      logic [2:0] c;
      if (v[6:3] == 4'hF)      c = (v[2:0] != 3'd0) ? CLS_NAN : CLS_INF;
      else if (v[6:3] == 4'h0) c = (v[2:0] != 3'd0) ? CLS_SUB : CLS_ZERO;
      else                     c = CLS_NORM;
      return c;
   endfunction

endpackage

>>> hw/rtl/fp8ea_decode.sv
// First stage: operand decode, special cases, compare/classify, small
// multiply and fp64 pre-shift. Depends on fp8ea_pkg.
module fp8ea_decode import fp8ea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [2:0]    mode,
   input  logic [7:0]    operand_a,
   input  logic [7:0]    operand_b,
   input  logic [7:0]    operand_c,
   input  logic [2:0]    round_mode,
   input  logic [63:0]   fp64_in,
   output fp8ea_ctl_type ctl_ff,
   output fp8ea_dec_type dec_ff
);

   fp8ea_ctl_type ctl_in;
   fp8ea_dec_type dec_in;

   logic [2:0] rm, ca, cb, cc;
   logic       a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, ps;
   logic [3:0] ma, mb, mc, sha, shb, shc;
   logic [1:0] cmp_code;
   logic [10:0] fe, kk;
   logic [63:0] mext;

   assign rm = (round_mode > RM_RD) ? RM_RZ : round_mode;
   assign ca = classify8(operand_a);
   assign cb = classify8(operand_b);
   assign cc = classify8(operand_c);
   assign a_nan = (ca == CLS_NAN);
   assign b_nan = (cb == CLS_NAN);
   assign c_nan = (cc == CLS_NAN);
   assign a_inf = (ca == CLS_INF);
   assign b_inf = (cb == CLS_INF);
   assign c_inf = (cc == CLS_INF);
   assign a_zero = (ca == CLS_ZERO);
   assign b_zero = (cb == CLS_ZERO);
   assign ps = operand_a[7] ^ operand_b[7];

   // significand and exponent - 1 (subnormals 0); the frame shift adds 9 to it
   assign ma  = {(operand_a[6:3] != 4'd0), operand_a[2:0]};
   assign mb  = {(operand_b[6:3] != 4'd0), operand_b[2:0]};
   assign mc  = {(operand_c[6:3] != 4'd0), operand_c[2:0]};
   assign sha = (operand_a[6:3] == 4'd0) ? 4'd0 : operand_a[6:3] - 4'd1;
   assign shb = (operand_b[6:3] == 4'd0) ? 4'd0 : operand_b[6:3] - 4'd1;
   assign shc = (operand_c[6:3] == 4'd0) ? 4'd0 : operand_c[6:3] - 4'd1;

   assign fe   = fp64_in[62:52];
   assign kk   = 11'd1057 - fe;
   assign mext = {11'd0, 1'b1, fp64_in[51:0]};

   always_comb begin
      if (a_nan || b_nan) begin
         cmp_code = CMP_UN;
      end else if (a_zero && b_zero) begin
         cmp_code = CMP_EQ;
      end else if (operand_a[7] != operand_b[7]) begin
         cmp_code = operand_a[7] ? CMP_LT : CMP_GT;
      end else if (operand_a[6:0] == operand_b[6:0]) begin
         cmp_code = CMP_EQ;
      end else if ((operand_a[6:0] < operand_b[6:0]) != operand_a[7]) begin
         cmp_code = CMP_LT;
      end else begin
         cmp_code = CMP_GT;
      end
   end

   always_comb begin
      ctl_in          = '0;
      dec_in          = '0;
      ctl_in.valid    = in_valid;
      ctl_in.rm       = rm;
      case (mode)
         MODE_ADD: begin
            dec_in.pm     = {4'd0, ma};
            dec_in.pshift = {1'b0, sha} + 5'd9;
            dec_in.psign  = operand_a[7];
            dec_in.cm     = mb;
            dec_in.cshift = {1'b0, shb} + 5'd9;
            dec_in.csign  = operand_b[7];
            ctl_in.zsign  = (operand_a[7] == operand_b[7]) ? operand_a[7] : (rm == RM_RD);
            if (a_nan || b_nan) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = FP8_QNAN;
            end else if (a_inf && b_inf) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = (operand_a[7] != operand_b[7]) ? FP8_QNAN : operand_a;
            end else if (a_inf) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = operand_a;
            end else if (b_inf) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = operand_b;
            end
         end
         MODE_MUL: begin
            dec_in.pm     = ma * mb;
            dec_in.pshift = {1'b0, sha} + {1'b0, shb};
            dec_in.psign  = ps;
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = FP8_QNAN;
            end else if (a_inf || b_inf) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = {ps, 7'h78};
            end else if (a_zero || b_zero) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = {ps, 7'h00};
            end
         end
         MODE_FMA: begin
            dec_in.pm     = ma * mb;
            dec_in.pshift = {1'b0, sha} + {1'b0, shb};
            dec_in.psign  = ps;
            dec_in.cm     = mc;
            dec_in.cshift = {1'b0, shc} + 5'd9;
            dec_in.csign  = operand_c[7];
            ctl_in.zsign  = (ps == operand_c[7]) ? ps : (rm == RM_RD);
            if (a_nan || b_nan || c_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = FP8_QNAN;
            end else if (a_inf || b_inf) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = (c_inf && (ps != operand_c[7])) ? FP8_QNAN : {ps, 7'h78};
            end else if (c_inf) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = operand_c;
            end
         end
         MODE_CMP: begin
            ctl_in.special = 1'b1;
            ctl_in.cmp     = cmp_code;
         end
         MODE_CLS: begin
            ctl_in.special = 1'b1;
            ctl_in.cls     = ca;
         end
         MODE_CVT: begin
            dec_in.use64 = 1'b1;
            dec_in.s64   = fp64_in[63];
            if (fe == 11'h7FF) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = (fp64_in[51:0] != 52'd0) ? FP8_QNAN : {fp64_in[63], 7'h78};
            end else if (fe == 11'd0) begin
               if (fp64_in[51:0] == 52'd0) begin
                  ctl_in.special  = 1'b1;
                  ctl_in.spec_res = {fp64_in[63], 7'h00};
               end else begin
                  dec_in.sticky = 1'b1;
               end
            end else if (fe >= 11'd1031) begin
               ctl_in.special  = 1'b1;
               ctl_in.spec_res = overflow8(fp64_in[63], rm);
            end else if (kk >= 11'd64) begin
               dec_in.sticky = 1'b1;
            end else begin
               // keep the frame bits, fold the rest into sticky
               dec_in.m64    = 27'(mext >> kk[5:0]);
               dec_in.sticky = |(mext << (7'd64 - {1'b0, kk[5:0]}));
            end
         end
         default: begin
            ctl_in.special = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      dec_ff <= dec_in;
   end

endmodule

>>> hw/rtl/fp8ea_align_add.sv
// Stages two and three: align and add product and addend in the fixed frame
// (or take the fp64 bits), then sign and magnitude. Depends on fp8ea_pkg.
module fp8ea_align_add import fp8ea_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  fp8ea_ctl_type     ctl_d,
   input  fp8ea_dec_type     dec_d,
   output fp8ea_ctl_type     ctl_ff,
   output logic              sign_ff,
   output logic [MagW-1:0]   mag_ff,
   output logic              sticky_ff
);

   fp8ea_ctl_type            ctl2_ff;
   logic signed [SumW-1:0]   sum_in, sum_ff;
   logic [MagW-1:0]          pf, cf;
   logic                     use64_ff, s64_ff, st2_ff;
   logic                     sign_in;
   logic [MagW-1:0]          mag_in;

   assign pf = MagW'(dec_d.pm) << dec_d.pshift;
   assign cf = MagW'(dec_d.cm) << dec_d.cshift;

   always_comb begin
      if (dec_d.use64) begin
         sum_in = signed'({8'd0, dec_d.m64});
      end else begin
         sum_in = (dec_d.psign ? -signed'({1'b0, pf}) : signed'({1'b0, pf}))
                + (dec_d.csign ? -signed'({1'b0, cf}) : signed'({1'b0, cf}));
      end
   end

   // fp64 keeps its own sign so a tiny value stays signed
   assign sign_in = use64_ff ? s64_ff : sum_ff[SumW-1];
   assign mag_in  = sum_ff[SumW-1] ? MagW'(-sum_ff) : MagW'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl_ff  <= '0;
      end else begin
         ctl2_ff <= ctl_d;
         ctl_ff  <= ctl2_ff;
      end
      sum_ff    <= sum_in;
      use64_ff  <= dec_d.use64;
      s64_ff    <= dec_d.s64;
      st2_ff    <= dec_d.sticky;
      sign_ff   <= sign_in;
      mag_ff    <= mag_in;
      sticky_ff <= st2_ff;
   end

endmodule

>>> hw/rtl/fp8ea_round.sv
// Stages four and five: leading-one detect, then round and pack to FP8 and
// drive the result registers. Depends on fp8ea_pkg.
module fp8ea_round import fp8ea_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fp8ea_ctl_type   ctl_d,
   input  logic            sign_d,
   input  logic [MagW-1:0] mag_d,
   input  logic            sticky_d,
   output logic            valid_ff,
   output logic [7:0]      result_ff,
   output logic [1:0]      cmp_ff,
   output logic [2:0]      cls_ff
);

   fp8ea_ctl_type   ctl4_ff;
   logic            sign4_ff, st4_ff;
   logic [MagW-1:0] mag4_ff;
   logic [5:0]      msb_in, msb4_ff;
   logic [4:0]      lpos, lm1, hexp;
   logic [3:0]      tr;
   logic            half, lower, bump, subn;
   logic [4:0]      tr5;
   logic [7:0]      code, res_in;
   logic [MagW-1:0] lowmask;

   always_comb begin
      msb_in = 6'd0;
      for (int i = 0; i < MagW; i++) begin
         if (mag_d[i]) msb_in = 6'(i);
      end
   end

   assign subn    = (msb4_ff < 6'd12);
   assign lpos    = subn ? 5'd9 : 5'(msb4_ff - 6'd3);
   assign lm1     = lpos - 5'd1;
   assign tr      = 4'(mag4_ff >> lpos);
   assign half    = mag4_ff[{1'b0, lm1}];
   assign lowmask = (MagW'(1) << lm1) - MagW'(1);
   assign lower   = (|(mag4_ff & lowmask)) | st4_ff;
   assign hexp    = subn ? 5'd0 : 5'(msb4_ff - 6'd12);
   assign tr5     = {1'b0, tr} + {4'd0, bump};
   assign code    = {hexp, 3'd0} + {3'd0, tr5};

   always_comb begin
      case (ctl4_ff.rm)
         RM_RNE:  bump = half && (lower || tr[0]);
         RM_RNA:  bump = half;
         RM_RU:   bump = (half || lower) && !sign4_ff;
         RM_RD:   bump = (half || lower) && sign4_ff;
         default: bump = 1'b0;
      endcase
   end

   always_comb begin
      if (ctl4_ff.special) begin
         res_in = ctl4_ff.spec_res;
      end else if ((mag4_ff == '0) && !st4_ff) begin
         res_in = {ctl4_ff.zsign, 7'd0};
      end else if (code >= 8'd120) begin
         res_in = overflow8(sign4_ff, ctl4_ff.rm);
      end else begin
         res_in = {sign4_ff, code[6:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         ctl4_ff  <= ctl_d;
         valid_ff <= ctl4_ff.valid;
      end
      sign4_ff  <= sign_d;
      mag4_ff   <= mag_d;
      st4_ff    <= sticky_d;
      msb4_ff   <= msb_in;
      result_ff <= res_in;
      cmp_ff    <= ctl4_ff.cmp;
      cls_ff    <= ctl4_ff.cls;
   end

endmodule

>>> hw/rtl/fp8_e4m3_arith_unit.sv
// FP8 E4M3 arithmetic unit, five-stage pipeline: decode, align/add, abs,
// leading-one detect, round/pack.
// Throughput one request per cycle; busy stays low, nothing ever stalls.
// Synchronous active-high reset clears the valid bits of every stage.
// Depends on fp8ea_pkg, fp8ea_decode, fp8ea_align_add, fp8ea_round.
module fp8_e4m3_arith_unit import fp8ea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_operand_a,
   input  logic [7:0]  req_operand_b,
   input  logic [7:0]  req_operand_c,
   input  logic [2:0]  req_round_mode,
   input  logic [63:0] req_fp64_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_fp8_result,
   output logic [1:0]  rsp_compare_code,
   output logic [2:0]  rsp_class_code
);

   fp8ea_ctl_type   ctl1, ctl3;
   fp8ea_dec_type   dec1;
   logic            sign3, sticky3;
   logic [MagW-1:0] mag3;

   assign busy = 1'b0;

   fp8ea_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .mode       (req_mode),
      .operand_a  (req_operand_a),
      .operand_b  (req_operand_b),
      .operand_c  (req_operand_c),
      .round_mode (req_round_mode),
      .fp64_in    (req_fp64_in),
      .ctl_ff     (ctl1),
      .dec_ff     (dec1)
   );

   fp8ea_align_add u_align_add (
      .clock     (clock),
      .reset     (reset),
      .ctl_d     (ctl1),
      .dec_d     (dec1),
      .ctl_ff    (ctl3),
      .sign_ff   (sign3),
      .mag_ff    (mag3),
      .sticky_ff (sticky3)
   );

   fp8ea_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl_d     (ctl3),
      .sign_d    (sign3),
      .mag_d     (mag3),
      .sticky_d  (sticky3),
      .valid_ff  (rsp_valid),
      .result_ff (rsp_fp8_result),
      .cmp_ff    (rsp_compare_code),
      .cls_ff    (rsp_class_code)
   );

endmodule

>>> hw/rtl/fp8ea_checker.sv
// Port-level checker for the FP8 E4M3 arithmetic unit, bound to the top.
// Depends on fp8ea_pkg and fp8_e4m3_arith_unit_defines.svh.
`include "fp8_e4m3_arith_unit_defines.svh"

module fp8ea_props import fp8ea_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_fp8_result,
   input logic [1:0] rsp_compare_code,
   input logic [2:0] rsp_class_code
);

   logic cmp_set, cls_set, fp8_clear, cls_legal;

   assign cmp_set   = (rsp_compare_code != CMP_LT);
   assign cls_set   = (rsp_class_code != CLS_ZERO);
   assign fp8_clear = (rsp_fp8_result == 8'd0);
   assign cls_legal = (rsp_class_code <= CLS_NAN);

   `FP8EA_ASSERT_ALWAYS(a_never_busy, !busy)
   `FP8EA_ASSERT_IMPL(a_latency, start && !busy, ##5 rsp_valid)
   `FP8EA_ASSERT_IMPL(a_cmp_only, rsp_valid && cmp_set, fp8_clear && !cls_set)
   `FP8EA_ASSERT_IMPL(a_cls_only, rsp_valid && cls_set, fp8_clear && cls_legal)

endmodule

bind fp8_e4m3_arith_unit fp8ea_props u_fp8ea_props (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_fp8_result   (rsp_fp8_result),
   .rsp_compare_code (rsp_compare_code),
   .rsp_class_code   (rsp_class_code)
);
